/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that vanish under synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* design/rcp_pkg.sv */
// ---------------------------------------------------------------------------
// rcp_pkg
// shared widths, codes and types of the radius pair weight sums block
// ---------------------------------------------------------------------------
package rcp_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int PT_W       = $clog2(MAX_POINTS);

  localparam int IDX_W  = 13;
  localparam int DIST_W = 24;
  localparam int WT_W   = 24;
  localparam int WSUM_W = 48;
  localparam int SQ_W   = 63;
  localparam int DEG_W  = 40;
  localparam int WSQ_W  = 2 * WT_W;

  localparam logic [IDX_W-1:0] POINT_COUNT_RESET = IDX_W'(4096);

  typedef enum logic [1:0] {
    FUNC_PAIR    = 2'd0,
    FUNC_CHECK   = 2'd1,
    FUNC_MARK    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_SUMS      = 2'd0,
    STATUS_BAD_INDEX = 2'd1,
    STATUS_ORDER     = 2'd2
  } status_t;

  typedef struct packed {
    logic [WSUM_W-1:0] weight_sum;
    logic [SQ_W-1:0]   square_sum;
    logic [SQ_W-1:0]   degree_square_sum;
    logic [WSUM_W-1:0] marked_sum;
  } sums_t;

  typedef struct packed {
    status_t           status;
    logic [WSUM_W-1:0] weight_sum;
    logic [SQ_W-1:0]   square_sum;
    logic [SQ_W-1:0]   degree_excess;
    logic [WSUM_W-1:0] marked_sum;
  } result_t;

  typedef struct packed {
    logic clear;
    logic start;
  } acc_ctrl_t;

  typedef struct packed {
    logic             en;
    logic [PT_W-1:0]  addr;
    logic [DEG_W-1:0] data;
  } deg_wr_t;

endpackage

/* design/rcp_in_if.sv */
// ---------------------------------------------------------------------------
// rcp_in_if
// input item channel: valid, ready and the item fields
// ---------------------------------------------------------------------------
interface rcp_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [rcp_pkg::IDX_W-1:0]   first_point;
  logic [rcp_pkg::IDX_W-1:0]   second_point;
  logic [rcp_pkg::DIST_W-1:0]  distance;
  logic [rcp_pkg::WT_W-1:0]    weight;
  logic                        mark;

  modport source (
    output valid, func, first_point, second_point, distance, weight, mark,
    input  ready
  );

  modport sink (
    input  valid, func, first_point, second_point, distance, weight, mark,
    output ready
  );
endinterface

/* design/rcp_out_if.sv */
// ---------------------------------------------------------------------------
// rcp_out_if
// result channel: valid, ready and the result fields
// ---------------------------------------------------------------------------
interface rcp_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [rcp_pkg::WSUM_W-1:0]  weight_sum;
  logic [rcp_pkg::SQ_W-1:0]    square_sum;
  logic [rcp_pkg::SQ_W-1:0]    degree_excess;
  logic [rcp_pkg::WSUM_W-1:0]  marked_sum;

  modport source (
    output valid, status, weight_sum, square_sum, degree_excess, marked_sum,
    input  ready
  );

  modport sink (
    input  valid, status, weight_sum, square_sum, degree_excess, marked_sum,
    output ready
  );
endinterface

/* design/rcp_deg_mem.sv */
// ---------------------------------------------------------------------------
// rcp_deg_mem
// per-point degree store, one write and one registered read port
// ---------------------------------------------------------------------------
module rcp_deg_mem (
  input  logic                        clk,
  input  rcp_pkg::deg_wr_t            wr,
  input  logic                        rd_en,
  input  logic [rcp_pkg::PT_W-1:0]    rd_addr,
  output logic [rcp_pkg::DEG_W-1:0]   rd_data
);
  import rcp_pkg::*;

  logic [DEG_W-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

/* design/rcp_mark_mem.sv */
// ---------------------------------------------------------------------------
// rcp_mark_mem
// per-point mark store, one write port and two registered read ports
// ---------------------------------------------------------------------------
module rcp_mark_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [rcp_pkg::PT_W-1:0]  wr_addr,
  input  logic                      wr_data,
  input  logic                      rd_en,
  input  logic [rcp_pkg::PT_W-1:0]  rd_addr_a,
  input  logic [rcp_pkg::PT_W-1:0]  rd_addr_b,
  output logic                      rd_a,
  output logic                      rd_b
);
  import rcp_pkg::*;

  logic mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end
endmodule

/* design/rcp_accum.sv */
// ---------------------------------------------------------------------------
// rcp_accum
// saturating sums and the stepped squared-degree increment
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rcp_accum (
  input  logic                       clk,
  input  logic                       rst,
  input  rcp_pkg::acc_ctrl_t         ctrl,
  input  logic [rcp_pkg::DEG_W-1:0]  old_deg,
  input  logic [rcp_pkg::WT_W-1:0]   weight,
  input  logic                       both_marked,
  output logic [rcp_pkg::DEG_W-1:0]  new_deg,
  output rcp_pkg::sums_t             sums,
  output logic                       busy
);
  import rcp_pkg::*;

  localparam int S_W    = DEG_W + 1;
  localparam int S_LO_W = 21;
  localparam int S_HI_W = S_W - S_LO_W;
  localparam int PLO_W  = WT_W + S_LO_W;
  localparam int PHI_W  = WT_W + S_HI_W;
  localparam int FULL_W = PHI_W + S_LO_W + 1;
  localparam logic [SQ_W-1:0] SQ_MAX = '1;

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_DIFF = 6'b000010,
    A_MLO  = 6'b000100,
    A_MHI  = 6'b001000,
    A_INC  = 6'b010000,
    A_ADD  = 6'b100000
  } acc_state_t;

  acc_state_t        state;
  logic [WSUM_W-1:0] weight_acc;
  logic [SQ_W-1:0]   square_acc;
  logic [SQ_W-1:0]   dsq_acc;
  logic [WSUM_W-1:0] marked_acc;
  logic [DEG_W-1:0]  nd_r;
  logic [DEG_W-1:0]  old_r;
  logic [WSQ_W-1:0]  wsq_r;
  logic [WT_W-1:0]   dlt_r;
  logic [S_W-1:0]    s_r;
  logic [PLO_W-1:0]  plo_r;
  logic [PHI_W-1:0]  phi_r;
  logic [SQ_W-1:0]   inc_r;

  logic [DEG_W:0]    deg_sum;
  logic [WSUM_W:0]   wsum_next;
  logic [WSUM_W:0]   msum_next;
  logic [SQ_W:0]     sq_next;
  logic [SQ_W:0]     dsq_next;
  logic [FULL_W-1:0] full;

  always_comb begin
    deg_sum   = {1'b0, old_deg} + (DEG_W + 1)'(weight);
    new_deg   = deg_sum[DEG_W] ? '1 : deg_sum[DEG_W-1:0];
    wsum_next = {1'b0, weight_acc} + (WSUM_W + 1)'(weight);
    msum_next = {1'b0, marked_acc} + (WSUM_W + 1)'(weight);
    sq_next   = {1'b0, square_acc} + (SQ_W + 1)'(wsq_r);
    dsq_next  = {1'b0, dsq_acc} + {1'b0, inc_r};
    full      = (FULL_W'(phi_r) << S_LO_W) + FULL_W'(plo_r);
  end

  assign busy = (state != A_IDLE);
  assign sums = '{weight_sum:        weight_acc,
                  square_sum:        square_acc,
                  degree_square_sum: dsq_acc,
                  marked_sum:        marked_acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= A_IDLE;
      weight_acc <= '0;
      square_acc <= '0;
      dsq_acc    <= '0;
      marked_acc <= '0;
    end else begin
      case (state)
        A_IDLE: begin
          if (ctrl.clear) begin
            weight_acc <= '0;
            square_acc <= '0;
            dsq_acc    <= '0;
            marked_acc <= '0;
          end else if (ctrl.start) begin
            nd_r       <= new_deg;
            old_r      <= old_deg;
            wsq_r      <= weight * weight;
            weight_acc <= wsum_next[WSUM_W] ? '1 : wsum_next[WSUM_W-1:0];
            if (both_marked) begin
              marked_acc <= msum_next[WSUM_W] ? '1 : msum_next[WSUM_W-1:0];
            end
            state <= A_DIFF;
          end
        end
        A_DIFF: begin
          dlt_r      <= WT_W'(nd_r - old_r);
          s_r        <= {1'b0, nd_r} + {1'b0, old_r};
          square_acc <= sq_next[SQ_W] ? '1 : sq_next[SQ_W-1:0];
          state      <= A_MLO;
        end
        A_MLO: begin
          plo_r <= PLO_W'(dlt_r) * PLO_W'(s_r[S_LO_W-1:0]);
          state <= A_MHI;
        end
        A_MHI: begin
          phi_r <= PHI_W'(dlt_r) * PHI_W'(s_r[S_W-1:S_LO_W]);
          state <= A_INC;
        end
        A_INC: begin
          inc_r <= (full[FULL_W-1:SQ_W] != '0) ? SQ_MAX : full[SQ_W-1:0];
          state <= A_ADD;
        end
        A_ADD: begin
          dsq_acc <= dsq_next[SQ_W] ? '1 : dsq_next[SQ_W-1:0];
          state   <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_start_when_idle, clk, rst, ctrl.start, state == A_IDLE)
  `ASSERT_NEXT(a_wsum_grows, clk, rst, !ctrl.clear, weight_acc >= $past(weight_acc))
  `ASSERT_NEXT(a_dsq_grows, clk, rst, !ctrl.clear, dsq_acc >= $past(dsq_acc))
endmodule

/* design/radius_cumulative_pair_weight_sums.sv */
// pair transaction: accepted, then the next transaction is taken only after the pair update finishes
// (one degree store read, then rcp_accum steps through A_DIFF, A_MLO, A_MHI, A_INC and A_ADD)
// checkpoint, mark, error: result registered next cycle if output free, else held in ST_HOLD; valid marks give none
// restart: sums clear at once, then a sweep zeroes every entry of the degree store (marks are kept)
// reset: synchronous; a sweep then clears every entry of the degree and mark stores
// ---------------------------------------------------------------------------
// radius_cumulative_pair_weight_sums
// accumulates weighted pair statistics and reports them at radius checkpoints
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module radius_cumulative_pair_weight_sums (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [rcp_pkg::IDX_W-1:0]  cfg_wr_data,
  rcp_in_if.sink                     pair_item,
  rcp_out_if.source                  result
);
  import rcp_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_HOLD  = 4'b1000
  } fsm_t;

  localparam logic [PT_W-1:0] CLR_LAST = PT_W'(MAX_POINTS - 1);

  fsm_t              state;
  logic [PT_W-1:0]   clr_cnt;
  logic              clr_marks;
  logic [IDX_W-1:0]  point_count;
  logic [DIST_W-1:0] last_radius;
  logic              radius_seen;
  logic [PT_W-1:0]   a_addr;
  logic [WT_W-1:0]   w_r;
  logic              out_valid;
  result_t           out_r;
  result_t           hold_r;

  func_t             func;
  logic              p1_ok;
  logic              p2_ok;
  logic [PT_W-1:0]   p1_addr;
  logic [PT_W-1:0]   p2_addr;
  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              has_res;
  logic              go_pair;
  logic              go_mark;
  result_t           res;
  deg_wr_t           deg_wr;
  logic [DEG_W-1:0]  deg_rd;
  logic [DEG_W-1:0]  new_deg;
  logic              mark_a;
  logic              mark_b;
  logic              mark_wr_en;
  logic [PT_W-1:0]   mark_wr_addr;
  logic              mark_wr_data;
  acc_ctrl_t         acc_ctrl;
  sums_t             sums;
  logic              acc_busy;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx,
                                  input logic [IDX_W-1:0] cnt);
    return (idx != '0) && (idx <= cnt) && (32'(idx) <= MAX_POINTS);
  endfunction

  assign func     = func_t'(pair_item.func);
  assign p1_ok    = idx_ok(pair_item.first_point, point_count);
  assign p2_ok    = idx_ok(pair_item.second_point, point_count);
  assign p1_addr  = PT_W'(pair_item.first_point - IDX_W'(1));
  assign p2_addr  = PT_W'(pair_item.second_point - IDX_W'(1));
  assign pair_item.ready = (state == ST_IDLE) && !acc_busy;
  assign accept   = pair_item.valid && pair_item.ready;
  assign out_free = !out_valid || result.ready;
  assign out_load = ((state == ST_IDLE) && accept && has_res && out_free) ||
                    ((state == ST_HOLD) && out_free);

  always_comb begin
    has_res = 1'b0;
    go_pair = 1'b0;
    go_mark = 1'b0;
    res     = '{status: STATUS_BAD_INDEX, default: '0};
    case (func)
      FUNC_PAIR: begin
        if (!(p1_ok && p2_ok)) begin
          has_res = 1'b1;
        end else if (radius_seen && (pair_item.distance <= last_radius)) begin
          has_res    = 1'b1;
          res.status = STATUS_ORDER;
        end else begin
          go_pair = 1'b1;
        end
      end
      FUNC_CHECK: begin
        has_res          = 1'b1;
        res.status       = STATUS_SUMS;
        res.weight_sum   = sums.weight_sum;
        res.square_sum   = sums.square_sum;
        res.degree_excess = (sums.degree_square_sum > sums.square_sum) ?
                            (sums.degree_square_sum - sums.square_sum) : '0;
        res.marked_sum   = sums.marked_sum;
      end
      FUNC_MARK: begin
        if (!p1_ok) begin
          has_res = 1'b1;
        end else begin
          go_mark = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // store write ports: sweep while clearing, otherwise normal updates
  always_comb begin
    deg_wr.en   = (state == ST_CLEAR) || (state == ST_READ);
    deg_wr.addr = (state == ST_CLEAR) ? clr_cnt : a_addr;
    deg_wr.data = (state == ST_CLEAR) ? '0 : new_deg;
    if (state == ST_CLEAR) begin
      mark_wr_en   = clr_marks;
      mark_wr_addr = clr_cnt;
      mark_wr_data = 1'b0;
    end else begin
      mark_wr_en   = accept && go_mark;
      mark_wr_addr = p1_addr;
      mark_wr_data = pair_item.mark;
    end
  end

  assign acc_ctrl.start = (state == ST_READ);
  assign acc_ctrl.clear = accept && (func == FUNC_RESTART);

  rcp_deg_mem u_deg_mem (
    .clk     (clk),
    .wr      (deg_wr),
    .rd_en   (accept),
    .rd_addr (p1_addr),
    .rd_data (deg_rd)
  );

  rcp_mark_mem u_mark_mem (
    .clk       (clk),
    .wr_en     (mark_wr_en),
    .wr_addr   (mark_wr_addr),
    .wr_data   (mark_wr_data),
    .rd_en     (accept),
    .rd_addr_a (p1_addr),
    .rd_addr_b (p2_addr),
    .rd_a      (mark_a),
    .rd_b      (mark_b)
  );

  rcp_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (acc_ctrl),
    .old_deg     (deg_rd),
    .weight      (w_r),
    .both_marked (mark_a && mark_b),
    .new_deg     (new_deg),
    .sums        (sums),
    .busy        (acc_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      clr_marks   <= 1'b1;
      point_count <= POINT_COUNT_RESET;
      last_radius <= '0;
      radius_seen <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        point_count <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          // counter wraps back to zero after the last entry
          clr_cnt <= clr_cnt + PT_W'(1);
          if (clr_cnt == CLR_LAST) begin
            clr_marks <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (has_res) begin
              if (out_free) begin
                out_r <= res;
              end else begin
                hold_r <= res;
                state  <= ST_HOLD;
              end
            end
            if (go_pair) begin
              a_addr <= p1_addr;
              w_r    <= pair_item.weight;
              state  <= ST_READ;
            end
            if (func == FUNC_CHECK) begin
              last_radius <= pair_item.distance;
              radius_seen <= 1'b1;
            end
            if (func == FUNC_RESTART) begin
              last_radius <= '0;
              radius_seen <= 1'b0;
              clr_cnt     <= '0;
              state       <= ST_CLEAR;
            end
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        ST_HOLD: begin
          if (out_free) begin
            out_r <= hold_r;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_r.status;
  assign result.weight_sum    = out_r.weight_sum;
  assign result.square_sum    = out_r.square_sum;
  assign result.degree_excess = out_r.degree_excess;
  assign result.marked_sum    = out_r.marked_sum;

  `ASSERT_NEXT(a_read_starts_unit, clk, rst, state == ST_READ, acc_busy)
  `ASSERT_IMPLIES(a_hold_has_output, clk, rst, state == ST_HOLD, out_valid)
  `ASSERT_IMPLIES(a_clear_writes_zero, clk, rst, state == ST_CLEAR, deg_wr.en && deg_wr.data == '0)
endmodule

/* tb/pair_sums_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pair_sums_checker
// watches the item and result channels, keeps its own copy of the pair
// sums, degrees and marks, and compares each result transaction with the
// oldest expected one
// ---------------------------------------------------------------------------
module pair_sums_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [rcp_pkg::IDX_W-1:0]  cfg_wr_data,
  rcp_in_if                          pair_item,
  rcp_out_if                         result,
  output int                         fail_count,
  output int                         pending
);
  import rcp_pkg::*;

  localparam logic [63:0] MAX40 = 64'h0000_00FF_FFFF_FFFF;
  localparam logic [63:0] MAX48 = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [IDX_W-1:0]  point_limit;
  logic [63:0]       weight_total;
  logic [63:0]       square_total;
  logic [63:0]       degree_square_total;
  logic [63:0]       marked_total;
  logic [DEG_W-1:0]  degree_tbl [MAX_POINTS];
  logic              mark_tbl [MAX_POINTS];
  logic [DIST_W-1:0] radius_bound;
  logic              bound_set;
  result_t           expected_results [$];
  int                mismatches = 0;

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] lim);
    if (a >= lim || b >= lim - a) return lim;
    return a + b;
  endfunction

  function automatic bit point_in_range(input logic [IDX_W-1:0] idx);
    return (idx != 0) && (idx <= point_limit) && (int'(idx) <= MAX_POINTS);
  endfunction

  task automatic clear_totals();
    weight_total = '0;
    square_total = '0;
    degree_square_total = '0;
    marked_total = '0;
    for (int i = 0; i < MAX_POINTS; i++) degree_tbl[i] = '0;
    radius_bound = '0;
    bound_set = 1'b0;
  endtask

  function automatic result_t make_result(input status_t st, input bit with_sums);
    result_t r;
    logic [63:0] excess;
    r = '0;
    r.status = st;
    if (with_sums) begin
      excess = (degree_square_total > square_total) ?
               degree_square_total - square_total : 64'd0;
      r.weight_sum = weight_total[WSUM_W-1:0];
      r.square_sum = square_total[SQ_W-1:0];
      r.degree_excess = excess[SQ_W-1:0];
      r.marked_sum = marked_total[WSUM_W-1:0];
    end
    return r;
  endfunction

  task automatic accumulate_pair(input int a, input int b, input logic [WT_W-1:0] w);
    logic [63:0] wide_w;
    logic [63:0] old_deg;
    logic [63:0] new_deg;
    logic [63:0] delta;
    logic [63:0] span;
    logic [63:0] incr;
    wide_w = 64'(w);
    weight_total = sat_sum(weight_total, wide_w, MAX48);
    square_total = sat_sum(square_total, wide_w * wide_w, MAX63);
    old_deg = 64'(degree_tbl[a]);
    new_deg = sat_sum(old_deg, wide_w, MAX40);
    degree_tbl[a] = new_deg[DEG_W-1:0];
    delta = new_deg - old_deg;
    span = new_deg + old_deg;
    if (span != 0 && delta > MAX63 / span) incr = MAX63;
    else incr = delta * span;
    degree_square_total = sat_sum(degree_square_total, incr, MAX63);
    if (mark_tbl[a] && mark_tbl[b]) marked_total = sat_sum(marked_total, wide_w, MAX48);
  endtask

  task automatic predict_item(input logic [1:0] op, input logic [IDX_W-1:0] a,
                              input logic [IDX_W-1:0] b, input logic [DIST_W-1:0] d,
                              input logic [WT_W-1:0] w, input logic m);
    case (func_t'(op))
      FUNC_PAIR: begin
        if (!point_in_range(a) || !point_in_range(b))
          expected_results.push_back(make_result(STATUS_BAD_INDEX, 1'b0));
        else if (bound_set && d <= radius_bound)
          expected_results.push_back(make_result(STATUS_ORDER, 1'b0));
        else
          accumulate_pair(int'(a) - 1, int'(b) - 1, w);
      end
      FUNC_CHECK: begin
        radius_bound = d;
        bound_set = 1'b1;
        expected_results.push_back(make_result(STATUS_SUMS, 1'b1));
      end
      FUNC_MARK: begin
        if (!point_in_range(a))
          expected_results.push_back(make_result(STATUS_BAD_INDEX, 1'b0));
        else
          mark_tbl[int'(a) - 1] = m;
      end
      default: clear_totals();
    endcase
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      point_limit = POINT_COUNT_RESET;
      for (int i = 0; i < MAX_POINTS; i++) mark_tbl[i] = 1'b0;
      clear_totals();
      expected_results.delete();
    end else begin
      if (cfg_wr_en) point_limit = cfg_wr_data;
      if (pair_item.valid && pair_item.ready)
        predict_item(pair_item.func, pair_item.first_point, pair_item.second_point,
                     pair_item.distance, pair_item.weight, pair_item.mark);
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction, status %h weight_sum %h",
                   $time, result.status, result.weight_sum);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(want.status), 64'(result.status));
          check_field("weight_sum", 64'(want.weight_sum), 64'(result.weight_sum));
          check_field("square_sum", 64'(want.square_sum), 64'(result.square_sum));
          check_field("degree_excess", 64'(want.degree_excess), 64'(result.degree_excess));
          check_field("marked_sum", 64'(want.marked_sum), 64'(result.marked_sum));
        end
      end
    end
    pending <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

/* tb/tb_radius_cumulative_pair_weight_sums.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_radius_cumulative_pair_weight_sums
// drives pair, checkpoint, mark and restart transactions in bursts under
// several point counts, stalls the result side, and reports the verdict
// from the checker's failure count
// ---------------------------------------------------------------------------
module tb_radius_cumulative_pair_weight_sums;
  import rcp_pkg::*;

  localparam int HOLD_OFF = 4200;
  localparam int LIMIT    = 20000;
  localparam int TAIL     = 50;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [IDX_W-1:0] cfg_wr_data;
  int               fail_count;
  int               pending;

  logic [IDX_W-1:0]  point_limit = POINT_COUNT_RESET;
  logic [DIST_W-1:0] radius_cursor = '0;
  int                burst_left = 0;
  int                stall_mode = 0;
  int                mode_left = 0;
  int                idle_cycles = 0;

  rcp_in_if  pair_item ();
  rcp_out_if result ();

  always #5 clk = ~clk;

  radius_cumulative_pair_weight_sums DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pair_item   (pair_item),
    .result      (result)
  );

  pair_sums_checker sums_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pair_item   (pair_item),
    .result      (result),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // result side stall pattern
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(40, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: result.ready <= 1'b1;
        1: result.ready <= ($urandom_range(0, 3) != 0);
        2: result.ready <= ($urandom_range(0, 3) == 0);
        default: result.ready <= ((mode_left % 9) < 6);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (pair_item.valid && pair_item.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= LIMIT) begin
      $display("tb_radius_cumulative_pair_weight_sums NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input func_t op, input logic [IDX_W-1:0] a,
                           input logic [IDX_W-1:0] b, input logic [DIST_W-1:0] d,
                           input logic [WT_W-1:0] w, input logic m);
    int gap;
    if (burst_left == 0) begin
      pair_item.valid <= 1'b0;
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    pair_item.valid <= 1'b1;
    pair_item.func <= op;
    pair_item.first_point <= a;
    pair_item.second_point <= b;
    pair_item.distance <= d;
    pair_item.weight <= w;
    pair_item.mark <= m;
    if (op == FUNC_CHECK) radius_cursor = d;
    else if (op == FUNC_RESTART) radius_cursor = '0;
    do @(posedge clk); while (!pair_item.ready);
  endtask

  task automatic drain();
    pair_item.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_point_count(input logic [IDX_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    point_limit = value;
  endtask

  function automatic logic [IDX_W-1:0] pick_point();
    int span;
    span = (int'(point_limit) > MAX_POINTS) ? MAX_POINTS : int'(point_limit);
    case ($urandom_range(0, 19))
      0: return IDX_W'($urandom_range(0, 8191));
      1: return (span == 0) ? IDX_W'(0) : IDX_W'($urandom_range(1, span));
      default: return (span == 0) ? IDX_W'($urandom_range(0, 3))
                                   : IDX_W'($urandom_range(1, (span < 8) ? span : 8));
    endcase
  endfunction

  function automatic logic [WT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return {WT_W{1'b1}};
      2: return WT_W'($urandom_range(1, 255));
      default: return WT_W'($urandom);
    endcase
  endfunction

  // well-formed pairs beyond the last radius, with checkpoints, marks,
  // restarts, broken pairs and raw noise mixed in
  task automatic random_items(input int count);
    int sel;
    func_t op;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [DIST_W-1:0] d;
    logic [WT_W-1:0] w;
    logic m;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      a = pick_point();
      b = pick_point();
      w = pick_weight();
      m = $urandom_range(0, 1);
      d = radius_cursor + DIST_W'($urandom_range(1, 2000));
      op = FUNC_PAIR;
      if (sel < 55) begin
        if (radius_cursor > 24'hFF_0000) op = FUNC_RESTART;
        else if ($urandom_range(0, 9) == 0) d = radius_cursor;
      end else if (sel < 70) begin
        op = FUNC_CHECK;
        if ($urandom_range(0, 7) == 0) d = DIST_W'($urandom);
        else d = radius_cursor + DIST_W'($urandom_range(0, 3000));
      end else if (sel < 82) begin
        op = FUNC_MARK;
      end else if (sel < 84) begin
        op = FUNC_RESTART;
      end else begin
        op = func_t'($urandom_range(0, 3));
        a = IDX_W'($urandom);
        b = IDX_W'($urandom);
        d = DIST_W'($urandom);
        w = WT_W'($urandom);
      end
      send_item(op, a, b, d, w, m);
    end
  endtask

  // heavy weights on one point to push the squared-degree sum into saturation
  task automatic hot_point_items(input int count);
    send_item(FUNC_RESTART, 0, 0, 0, 0, 0);
    send_item(FUNC_MARK, 2, 0, 0, 0, 1'b1);
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 19)
        send_item(FUNC_CHECK, 0, 0, radius_cursor + 24'd50, 0, 0);
      else
        send_item(FUNC_PAIR, 1, 2, radius_cursor + DIST_W'($urandom_range(1, 100)),
                  24'hFF_FFFF - WT_W'($urandom_range(0, 255)), 0);
    end
  endtask

  task automatic run_phase(input logic [IDX_W-1:0] value, input int count);
    drain();
    repeat (HOLD_OFF) @(posedge clk);
    write_point_count(value);
    random_items(count);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    pair_item.valid <= 1'b0;
    pair_item.func <= FUNC_PAIR;
    pair_item.first_point <= '0;
    pair_item.second_point <= '0;
    pair_item.distance <= '0;
    pair_item.weight <= '0;
    pair_item.mark <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_point_count(IDX_W'(4096));

    send_item(FUNC_CHECK, 0, 0, 24'd0, 24'd0, 0);
    send_item(FUNC_MARK, 1, 0, 0, 0, 1'b1);
    send_item(FUNC_MARK, 2, 0, 0, 0, 1'b1);
    send_item(FUNC_MARK, 4096, 0, 0, 0, 1'b1);
    send_item(FUNC_PAIR, 1, 2, 24'd1, 24'hFF_FFFF, 0);
    send_item(FUNC_PAIR, 2, 1, 24'd2, 24'd0, 1'b1);
    send_item(FUNC_PAIR, 4096, 4096, 24'd3, 24'd1, 0);
    send_item(FUNC_PAIR, 0, 1, 24'd4, 24'd5, 0);
    send_item(FUNC_PAIR, 1, 8191, 24'd4, 24'd5, 0);
    send_item(FUNC_PAIR, 4097, 1, 24'd4, 24'd5, 0);
    send_item(FUNC_CHECK, 0, 0, 24'd10, 24'hFF_FFFF, 1'b1);
    send_item(FUNC_PAIR, 1, 2, 24'd10, 24'd7, 0);
    send_item(FUNC_PAIR, 1, 2, 24'd5, 24'd7, 0);
    send_item(FUNC_PAIR, 0, 2, 24'd5, 24'd7, 0);
    send_item(FUNC_CHECK, 0, 0, 24'd4, 24'd0, 0);
    send_item(FUNC_PAIR, 3, 4, 24'd5, 24'h80_0000, 0);
    send_item(FUNC_MARK, 0, 0, 0, 0, 1'b1);
    send_item(FUNC_MARK, 8191, 8191, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
    send_item(FUNC_MARK, 4097, 0, 0, 0, 0);
    send_item(FUNC_MARK, 2, 0, 0, 0, 0);
    send_item(FUNC_PAIR, 5, 6, 24'hFF_FFFF, 24'h12_3456, 1'b1);
    send_item(FUNC_CHECK, 8191, 8191, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
    send_item(FUNC_PAIR, 5, 6, 24'hFF_FFFF, 24'd1, 0);
    send_item(FUNC_RESTART, 0, 0, 0, 0, 0);
    send_item(FUNC_CHECK, 0, 0, 24'd0, 24'd0, 0);
    send_item(FUNC_PAIR, 1, 2, 24'd0, 24'hFF_FFFF, 0);
    send_item(FUNC_CHECK, 0, 0, 24'd1, 24'd0, 0);

    hot_point_items(300);
    random_items(400);
    run_phase(IDX_W'(1), 150);
    run_phase(IDX_W'(8191), 200);
    run_phase(IDX_W'(0), 60);
    run_phase(IDX_W'(5), 150);
    run_phase(IDX_W'(4096), 150);

    drain();
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_radius_cumulative_pair_weight_sums OK");
    end else begin
      $display("tb_radius_cumulative_pair_weight_sums NOT OK");
    end
    $finish;
  end

endmodule
